>>> rtl/sst_pkg.sv
// sst_pkg: shared types, codes and reset constants of the sensor self-test checker
// used by every module under rtl; depends on nothing
package sst_pkg;

	localparam int SAMPLES_DEFAULT = 16;

	localparam logic [15:0] WINDOW_LOW_RESET  = 16'd300;
	localparam logic [15:0] WINDOW_HIGH_RESET = 16'd15000;

	// axis index after the last axis has been judged
	localparam logic [1:0] AXIS_LAST     = 2'd2;
	localparam logic [1:0] AXIS_FINISHED = 2'd3;

	localparam int QUO_W = 17;

	// item operation codes
	localparam logic OP_START  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// configuration register indexes
	localparam logic CFG_WINDOW_LOW  = 1'b0;
	localparam logic CFG_WINDOW_HIGH = 1'b1;

	// control word that travels with each item
	typedef struct packed {
		logic       start;       // item restarted the test
		logic       complete;    // item closed an averaging phase
		logic       phase_on;    // closed phase had the actuator on
		logic [1:0] axis;        // axis whose phase was closed
		logic       actuator_on;
		logic [1:0] read_axis;
		logic       done;
	} ctl_t;

	// second stage payload
	typedef struct packed {
		ctl_t             ctl;
		logic             neg;   // sum was negative
		logic [QUO_W-1:0] quo;   // magnitude of the truncated average
	} div_t;

endpackage

>>> rtl/sensor_self_test_checker.sv
// sensor_self_test_checker: top level of the three-axis sensor self-test checker
// holds the window registers and the stage handshake; depends on sst_pkg,
// sst_front, sst_divide and sst_judge
//
//  channel | signals                               | dir | transfer
//  --------+---------------------------------------+-----+---------------------------
//  item    | item_valid item_stall operation sample | in  | item_valid & !item_stall
//  result  | res_valid res_stall actuator_on         | out | res_valid & !res_stall
//          | read_axis done_res axis_pass all_pass   |     |
//  config  | cfg_valid cfg_ready cfg_index cfg_data  | in  | cfg_valid & cfg_ready
//
// one item per cycle while item_stall is low; each item gives one result, shown
// once the item has passed three registers (sequencer/accumulator stage,
// reciprocal multiply stage, window check stage)
// arst_n clears the sequencer, the stage valids and the pass mask, and loads
// the window registers with 300 and 15000
// a stalled result holds; the stages behind it keep filling, so item_stall
// rises only once all three stages hold items
// cfg_ready is always high; windows are read by the last stage
module sensor_self_test_checker import sst_pkg::*; #(
	parameter int SAMPLES_PER_AVERAGE = SAMPLES_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	// item channel
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               operation,
	input  logic signed [15:0] sample,
	// result channel
	output logic               res_valid,
	input  logic               res_stall,
	output logic               actuator_on,
	output logic [1:0]         read_axis,
	output logic               done_res,
	output logic [2:0]         axis_pass,
	output logic               all_pass,
	// configuration channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int SumW = 16 + $clog2(SAMPLES_PER_AVERAGE);

	logic                   accept;
	logic                   adv2;
	logic                   adv3;
	logic                   valid_s1;
	logic                   valid_s2;
	ctl_t                   ctl_s1;
	logic signed [SumW-1:0] sum_s1;
	div_t                   div_s2;
	logic [15:0]            window_low_q;
	logic [15:0]            window_high_q;

	// stage advance chain, from the result end backward
	assign adv3       = valid_s2 && (!res_valid || !res_stall);
	assign adv2       = valid_s1 && (!valid_s2 || adv3);
	assign item_stall = valid_s1 && !adv2;
	assign accept     = item_valid && !item_stall;

	assign cfg_ready = 1'b1;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_low_q  <= WINDOW_LOW_RESET;
			window_high_q <= WINDOW_HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WINDOW_LOW:  window_low_q  <= cfg_data;
				CFG_WINDOW_HIGH: window_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and accumulator
	sst_front #(
		.SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.operation(operation),
		.sample   (sample),
		.adv2     (adv2),
		.valid_s1 (valid_s1),
		.ctl_s1   (ctl_s1),
		.sum_s1   (sum_s1)
	);

	// average of a closed phase
	sst_divide #(
		.SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
	) u_divide (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv2    (adv2),
		.adv3    (adv3),
		.ctl_s1  (ctl_s1),
		.sum_s1  (sum_s1),
		.valid_s2(valid_s2),
		.div_s2  (div_s2)
	);

	// response window check and result register
	sst_judge u_judge (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv3       (adv3),
		.res_stall  (res_stall),
		.div_s2     (div_s2),
		.window_low (window_low_q),
		.window_high(window_high_q),
		.res_valid  (res_valid),
		.actuator_on(actuator_on),
		.read_axis  (read_axis),
		.done_res   (done_res),
		.axis_pass  (axis_pass),
		.all_pass   (all_pass)
	);

	// the item side stalls only with every stage occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && valid_s2 && res_valid))
		else $error("item stall with a free stage");

	// a start item reaches the first stage as a fresh, unfinished test
	a_start_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_START) |=> (valid_s1 && ctl_s1.start && !ctl_s1.done))
		else $error("start item lost in first stage");

	// a finished test leaves the actuator off and the axis at zero
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && done_res) |-> (!actuator_on && read_axis == 2'd0))
		else $error("done result with actuator or axis active");

	// all-pass only with done and a full mask
	a_all_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && all_pass) |-> (done_res && axis_pass == 3'b111))
		else $error("all-pass without a complete pass mask");

endmodule

>>> rtl/sst_front.sv
// sst_front: test sequencer and sample accumulator, first pipeline stage
// depends on sst_pkg
module sst_front import sst_pkg::*; #(
	parameter int SAMPLES_PER_AVERAGE = SAMPLES_DEFAULT,
	localparam int SumW = 16 + $clog2(SAMPLES_PER_AVERAGE)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic                   operation,
	input  logic signed [15:0]     sample,
	input  logic                   adv2,
	output logic                   valid_s1,
	output ctl_t                   ctl_s1,
	output logic signed [SumW-1:0] sum_s1
);

	localparam int CntW = $clog2(SAMPLES_PER_AVERAGE);
	localparam logic [CntW-1:0] CntLast = CntW'(SAMPLES_PER_AVERAGE - 1);

	logic                   running_q, running_n;
	logic [1:0]             axis_q, axis_n;
	logic                   phase_q, phase_n;
	logic [CntW-1:0]        cnt_q, cnt_n;
	logic signed [SumW-1:0] sum_q, sum_n;
	logic signed [SumW-1:0] total;
	ctl_t                   ctl_n;

	assign total = sum_q + $signed({{(SumW-16){sample[15]}}, sample});

	always_comb begin
		running_n = running_q;
		axis_n    = axis_q;
		phase_n   = phase_q;
		cnt_n     = cnt_q;
		sum_n     = sum_q;
		ctl_n     = '0;
		if (operation == OP_START) begin
			running_n  = 1'b1;
			axis_n     = '0;
			phase_n    = 1'b0;
			cnt_n      = '0;
			sum_n      = '0;
			ctl_n.start = 1'b1;
		end else if (running_q) begin
			if (cnt_q == CntLast) begin
				cnt_n          = '0;
				sum_n          = '0;
				ctl_n.complete = 1'b1;
				ctl_n.phase_on = phase_q;
				ctl_n.axis     = axis_q;
				if (!phase_q) begin
					phase_n = 1'b1;
				end else begin
					phase_n = 1'b0;
					if (axis_q == AXIS_LAST) begin
						axis_n    = AXIS_FINISHED;
						running_n = 1'b0;
					end else begin
						axis_n = axis_q + 2'd1;
					end
				end
			end else begin
				cnt_n = cnt_q + CntW'(1);
				sum_n = total;
			end
		end
		ctl_n.actuator_on = running_n & phase_n;
		ctl_n.read_axis   = running_n ? axis_n : 2'd0;
		ctl_n.done        = !running_n && (axis_n == AXIS_FINISHED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			axis_q    <= '0;
			phase_q   <= 1'b0;
			cnt_q     <= '0;
			sum_q     <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (accept) begin
				running_q <= running_n;
				axis_q    <= axis_n;
				phase_q   <= phase_n;
				cnt_q     <= cnt_n;
				sum_q     <= sum_n;
				valid_s1  <= 1'b1;
			end else if (adv2) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_n;
			sum_s1 <= total;
		end
	end

endmodule

>>> rtl/sst_divide.sv
// sst_divide: truncating divide of the phase sum by the sample count, second stage
// reciprocal multiply on the magnitude; depends on sst_pkg
module sst_divide import sst_pkg::*; #(
	parameter int SAMPLES_PER_AVERAGE = SAMPLES_DEFAULT,
	localparam int SumW = 16 + $clog2(SAMPLES_PER_AVERAGE)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv2,
	input  logic                   adv3,
	input  ctl_t                   ctl_s1,
	input  logic signed [SumW-1:0] sum_s1,
	output logic                   valid_s2,
	output div_t                   div_s2
);

	// exact for every magnitude below 2**SumW
	localparam int RecipShift = SumW + $clog2(SAMPLES_PER_AVERAGE);
	localparam int RecipW     = SumW + 2;
	localparam int ProdW      = SumW + RecipW;
	localparam logic [63:0] RecipBase = 64'd1 << RecipShift;
	localparam logic [RecipW-1:0] Recip = RecipW'((RecipBase
		+ 64'(SAMPLES_PER_AVERAGE) - 64'd1) / 64'(SAMPLES_PER_AVERAGE));

	logic [SumW-1:0]  mag;
	logic [ProdW-1:0] prod;
	div_t             div_n;

	assign mag  = sum_s1[SumW-1] ? (~sum_s1 + SumW'(1)) : sum_s1;
	assign prod = ProdW'(mag) * ProdW'(Recip);

	always_comb begin
		div_n.ctl = ctl_s1;
		div_n.neg = sum_s1[SumW-1];
		div_n.quo = prod[RecipShift +: QUO_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= 1'b1;
		end else if (adv3) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			div_s2 <= div_n;
		end
	end

endmodule

>>> rtl/sst_judge.sv
// sst_judge: window check of the self-test response, pass mask and result register
// last stage; depends on sst_pkg
module sst_judge import sst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv3,
	input  logic        res_stall,
	input  div_t        div_s2,
	input  logic [15:0] window_low,
	input  logic [15:0] window_high,
	output logic        res_valid,
	output logic        actuator_on,
	output logic [1:0]  read_axis,
	output logic        done_res,
	output logic [2:0]  axis_pass,
	output logic        all_pass
);

	logic [15:0]      off_avg_q;
	logic [2:0]       mask_q, mask_n;
	logic [QUO_W-1:0] avg;
	logic [17:0]      diff;
	logic [16:0]      resp;
	logic             in_window;

	assign avg  = div_s2.neg ? (~div_s2.quo + QUO_W'(1)) : div_s2.quo;
	assign diff = {avg[16], avg} - {{2{off_avg_q[15]}}, off_avg_q};
	assign resp = diff[17] ? 17'(~diff + 18'd1) : diff[16:0];
	assign in_window = (resp >= {1'b0, window_low}) && (resp <= {1'b0, window_high});

	always_comb begin
		mask_n = mask_q;
		if (div_s2.ctl.start) begin
			mask_n = '0;
		end else if (div_s2.ctl.complete && div_s2.ctl.phase_on && in_window) begin
			mask_n = mask_q | (3'd1 << div_s2.ctl.axis);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid   <= 1'b0;
			mask_q      <= '0;
			off_avg_q   <= '0;
			actuator_on <= 1'b0;
			read_axis   <= '0;
			done_res    <= 1'b0;
			all_pass    <= 1'b0;
		end else begin
			if (adv3) begin
				res_valid   <= 1'b1;
				mask_q      <= mask_n;
				actuator_on <= div_s2.ctl.actuator_on;
				read_axis   <= div_s2.ctl.read_axis;
				done_res    <= div_s2.ctl.done;
				all_pass    <= div_s2.ctl.done && (mask_n == 3'b111);
				if (div_s2.ctl.start) begin
					off_avg_q <= '0;
				end else if (div_s2.ctl.complete && !div_s2.ctl.phase_on) begin
					off_avg_q <= avg[15:0];
				end
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
		end
	end

	assign axis_pass = mask_q;

endmodule
